@@ src/rrpes_pkg.sv @@
// package for the round-robin pending event selector
// sizes, opcodes, controller states and the controller/datapath command struct; no dependencies
package rrpes_pkg;

    // table size and counter width
    localparam int NUM_SOURCES = 32;
    localparam int COUNT_WIDTH = 16;
    localparam int IDX_W       = (NUM_SOURCES > 1) ? $clog2(NUM_SOURCES) : 1;

    // fixed field widths of the item and result ports
    localparam int OP_W    = 2;
    localparam int SID_W   = 6;
    localparam int CID_W   = 5;
    localparam int CCNT_W  = 16;
    localparam int TOTAL_W = 16;

    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

    // opcodes
    localparam logic [OP_W-1:0] OP_POST   = 2'd0;
    localparam logic [OP_W-1:0] OP_CHOOSE = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

    // controller states
    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

    // commands from controller to datapath
    typedef struct packed {
        logic capture;
        logic commit;
    } ctrl_cmd_t;

endpackage

@@ src/rrpes_ctrl.sv @@
// controller of the pending event selector: item sequencing and output valid
// depends on rrpes_pkg
module rrpes_ctrl import rrpes_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    output logic      m_valid,
    input  logic      m_ready,
    output ctrl_cmd_t cmd
);

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;

    // state and output valid registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // next state and commands
    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg;
        cmd          = '0;
        // result taken downstream
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_EXEC;
                end
            end
            ST_EXEC: begin
                // commit once the output register is free
                if (!m_valid_reg || m_ready) begin
                    cmd.commit   = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;

endmodule

@@ src/rrpes_dp.sv @@
// datapath of the pending event selector: counter memory, pending bitmap,
// round-robin encoder, total and pointer registers, result register; uses rrpes_pkg
module rrpes_dp import rrpes_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  ctrl_cmd_t           cmd,
    input  logic [OP_W-1:0]     s_opcode,
    input  logic [SID_W-1:0]    s_source_id,
    output logic                m_found,
    output logic [CID_W-1:0]    m_chosen_id,
    output logic [CCNT_W-1:0]   m_chosen_count,
    output logic                m_bad_id,
    output logic [TOTAL_W-1:0]  m_total_pending
);

    // per-source counters; an entry is meaningful only while its pending bit is set
    logic [COUNT_WIDTH-1:0] cnt_mem [NUM_SOURCES];

    logic [NUM_SOURCES-1:0] pend_reg, pend_next;
    logic [IDX_W-1:0]       ptr_reg, ptr_next;
    logic [COUNT_WIDTH-1:0] total_reg, total_next;

    // item captured at acceptance
    logic [OP_W-1:0]        op_reg;
    logic                   bad_reg;
    logic                   hit_reg;
    logic [IDX_W-1:0]       addr_reg;
    logic [COUNT_WIDTH-1:0] rd_reg;

    // result register
    logic                   found_reg, found_next;
    logic [CID_W-1:0]       cid_reg, cid_next;
    logic [CCNT_W-1:0]      ccnt_reg, ccnt_next;
    logic                   badout_reg, badout_next;
    logic [TOTAL_W-1:0]     tout_reg;

    logic [NUM_SOURCES-1:0] above;
    logic [IDX_W-1:0]       enc_idx;
    logic                   enc_any;
    logic [IDX_W-1:0]       rd_addr;
    logic                   in_bad;
    logic                   wr_en;
    logic [COUNT_WIDTH-1:0] wr_data;

    function automatic logic [IDX_W-1:0] lowest_set(input logic [NUM_SOURCES-1:0] v);
        logic [IDX_W-1:0] r;
        r = '0;
        for (int i = NUM_SOURCES - 1; i >= 0; i--) begin
            if (v[i]) r = IDX_W'(i);
        end
        return r;
    endfunction

    // round-robin encoder: first pending source after the pointer, wrapping
    always_comb begin
        for (int i = 0; i < NUM_SOURCES; i++) begin
            above[i] = pend_reg[i] && (IDX_W'(i) > ptr_reg);
        end
        enc_any = |pend_reg;
        enc_idx = (|above) ? lowest_set(above) : lowest_set(pend_reg);
    end

    // read address and range check at acceptance
    assign rd_addr = (s_opcode == OP_CHOOSE) ? enc_idx : s_source_id[IDX_W-1:0];
    assign in_bad  = (int'(s_source_id) >= NUM_SOURCES);

    // capture the item and read its counter
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            op_reg   <= s_opcode;
            bad_reg  <= in_bad;
            addr_reg <= rd_addr;
            hit_reg  <= (s_opcode == OP_CHOOSE) ? enc_any : pend_reg[rd_addr];
            rd_reg   <= cnt_mem[rd_addr];
        end
    end

    // counter memory write
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            cnt_mem[addr_reg] <= wr_data;
        end
    end

    // commit: state update and result
    always_comb begin
        pend_next   = pend_reg;
        ptr_next    = ptr_reg;
        total_next  = total_reg;
        wr_en       = 1'b0;
        wr_data     = COUNT_WIDTH'(1);
        found_next  = 1'b0;
        cid_next    = '0;
        ccnt_next   = '0;
        badout_next = 1'b0;
        case (op_reg)
            OP_POST: begin
                if (bad_reg) begin
                    badout_next = 1'b1;
                end else begin
                    wr_en = cmd.commit;
                    // an entry without its pending bit counts as zero
                    if (hit_reg) begin
                        wr_data = (rd_reg == COUNT_MAX) ? rd_reg : rd_reg + COUNT_WIDTH'(1);
                    end
                    pend_next[addr_reg] = 1'b1;
                    total_next = (total_reg == COUNT_MAX) ? total_reg
                                                          : total_reg + COUNT_WIDTH'(1);
                end
            end
            OP_CHOOSE: begin
                if (hit_reg) begin
                    found_next          = 1'b1;
                    cid_next            = CID_W'(addr_reg);
                    ccnt_next           = CCNT_W'(rd_reg);
                    pend_next[addr_reg] = 1'b0;
                    ptr_next            = addr_reg;
                    // subtraction floors at zero
                    total_next = (total_reg > rd_reg) ? total_reg - rd_reg : '0;
                end
            end
            OP_CLEAR: begin
                pend_next = '0;
            end
            default: ;
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg  <= '0;
            ptr_reg   <= '0;
            total_reg <= '0;
        end else if (cmd.commit) begin
            pend_reg  <= pend_next;
            ptr_reg   <= ptr_next;
            total_reg <= total_next;
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            found_reg  <= found_next;
            cid_reg    <= cid_next;
            ccnt_reg   <= ccnt_next;
            badout_reg <= badout_next;
            tout_reg   <= TOTAL_W'(total_next);
        end
    end

    assign m_found         = found_reg;
    assign m_chosen_id     = cid_reg;
    assign m_chosen_count  = ccnt_reg;
    assign m_bad_id        = badout_reg;
    assign m_total_pending = tout_reg;

endmodule

@@ src/round_robin_pending_event_selector.sv @@
// top level of the round-robin pending event selector
// an accepted item is captured, then committed once the output register is free
// items go one at a time, set by the capture/commit sequence around the
//   single-port counter memory; a stalled result holds the next item
// reset: clears the pending bitmap (all counters read as zero), the scan pointer,
//   the total and the output valid; no clearing pass, ready right after reset
module round_robin_pending_event_selector import rrpes_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [OP_W-1:0]     s_opcode,
    input  logic [SID_W-1:0]    s_source_id,
    output logic                m_valid,
    input  logic                m_ready,
    output logic                m_found,
    output logic [CID_W-1:0]    m_chosen_id,
    output logic [CCNT_W-1:0]   m_chosen_count,
    output logic                m_bad_id,
    output logic [TOTAL_W-1:0]  m_total_pending
);

    ctrl_cmd_t cmd;

    // sequencing
    rrpes_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    // storage, selection and result
    rrpes_dp u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .s_opcode        (s_opcode),
        .s_source_id     (s_source_id),
        .m_found         (m_found),
        .m_chosen_id     (m_chosen_id),
        .m_chosen_count  (m_chosen_count),
        .m_bad_id        (m_bad_id),
        .m_total_pending (m_total_pending)
    );

endmodule

@@ src/rrpes_checker.sv @@
// port-level checks for the pending event selector, bound to the top level
// depends on rrpes_pkg
module rrpes_checker import rrpes_pkg::*; (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input logic [OP_W-1:0]     s_opcode,
    input logic [SID_W-1:0]    s_source_id,
    input logic                m_valid,
    input logic                m_ready,
    input logic                m_found,
    input logic [CID_W-1:0]    m_chosen_id,
    input logic [CCNT_W-1:0]   m_chosen_count,
    input logic                m_bad_id,
    input logic [TOTAL_W-1:0]  m_total_pending
);

    // a stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_found) && $stable(m_chosen_id)
            && $stable(m_chosen_count) && $stable(m_bad_id) && $stable(m_total_pending))
        else $error("result changed while stalled");

    // an accepted item keeps the input closed for the next cycle
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input ready right after an item");

    // a chosen source always carries pending occurrences
    a_found_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_found |-> m_chosen_count != '0 && !m_bad_id)
        else $error("chosen source with zero count");

    // no choice reported means empty choice fields
    a_not_found: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_found |-> m_chosen_count == '0 && m_chosen_id == '0)
        else $error("choice fields set without a found source");

endmodule

bind round_robin_pending_event_selector rrpes_checker u_rrpes_checker (.*);
